// ===== hdl/bra_pkg.sv =====
// ----------------------------------------------------------------------------
// bra_pkg
// Shared widths, request codes and control types of the bitmap run allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bra_pkg;

    // Default store size in bytes
    localparam int unsigned MAP_BYTES_DEF = 512;

    // Fixed field widths
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned BIT_IDX_W  = 12;
    localparam int unsigned RUN_LEN_W  = 13;
    localparam int unsigned MAP_CFG_W  = 10;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned BYTE_IDX_W = BIT_IDX_W - 3;

    // Reset value of the map length register
    localparam logic [MAP_CFG_W-1:0] MAP_CFG_RESET = MAP_CFG_W'(512);

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_SCAN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TEST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

    // Sequencer to run unit control
    typedef struct packed {
        logic                 init;
        logic                 eval;
        logic [RUN_LEN_W-1:0] run_length;
    } run_ctrl_t;

    // Run unit status back to the sequencer
    typedef struct packed {
        logic                 found;
        logic [BIT_IDX_W-1:0] start_index;
    } run_stat_t;

endpackage

`default_nettype wire

// ===== hdl/bra_chan_if.sv =====
// ----------------------------------------------------------------------------
// bra_chan_if
// Request and response channels of the bitmap run allocator (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface bra_req_if;
    import bra_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [BIT_IDX_W-1:0] bit_index;
    logic                 set_value;
    logic [RUN_LEN_W-1:0] run_length;

    modport source (output valid, output kind, output bit_index, output set_value,
                    output run_length, input ready);
    modport sink   (input valid, input kind, input bit_index, input set_value,
                    input run_length, output ready);
endinterface

interface bra_rsp_if;
    import bra_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [BIT_IDX_W-1:0] start_index;
    logic                 bit_value;

    modport source (output valid, output found, output start_index, output bit_value,
                    input ready);
    modport sink   (input valid, input found, input start_index, input bit_value,
                     output ready);
endinterface

`default_nettype wire

// ===== hdl/bitmap_run_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_run_allocator_core
// First-fit contiguous-run bitmap allocator over a byte-wide map memory.
// ----------------------------------------------------------------------------
// Usage:
//   req  (valid/ready): kind, bit_index, set_value, run_length. One item
//        is taken at a time; req.ready is high only while the block is idle.
//   rsp  (valid/ready): found, start_index, bit_value, one item per request,
//        held in an output register until taken.
//   cfg_we/cfg_wdata: writes map_bytes (bytes in use); write only while idle.
// Steps (from acceptance to the item showing on rsp):
//   test, set: read, evaluate, finish, output register.
//   scan: one map byte a cycle through the run unit, then finish and the
//         output register; it ends early at the first fitting run.
//   clear: one memory byte zeroed per cycle over the store, then finish.
// Reset: the map memory is swept to zero with req.ready low; map_bytes
//   returns to 512.
// Stall: a finished item waits in the output register; a new request may be
//   taken meanwhile and completes its work, then waits for that register.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_run_allocator_core #(
    parameter int unsigned MAP_BYTES = bra_pkg::MAP_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bra_pkg::MAP_CFG_W-1:0]   cfg_wdata,
    bra_req_if.sink                              req,
    bra_rsp_if.source                            rsp
);
    import bra_pkg::*;

    localparam int unsigned AW   = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int unsigned CW   = $clog2(MAP_BYTES + 1);
    localparam int unsigned UW   = (CW > MAP_CFG_W) ? CW : MAP_CFG_W;
    localparam int unsigned CMPW = (CW > BYTE_IDX_W) ? CW : BYTE_IDX_W;

    // Sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_BIT_RD = 3'd3;
    localparam logic [2:0] ST_BIT_EV = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]           state_reg,     state_next;
    logic [MAP_CFG_W-1:0] map_bytes_reg, map_bytes_next;
    logic [AW-1:0]        clr_cnt_reg,   clr_cnt_next;
    logic                 clr_item_reg,  clr_item_next;
    logic [CW-1:0]        issue_cnt_reg, issue_cnt_next;
    logic                 pend_reg,      pend_next;
    logic [CW-1:0]        eval_idx_reg,  eval_idx_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic [KIND_W-1:0]    kind_reg,      kind_next;
    logic [AW-1:0]        addr_reg,      addr_next;
    logic [2:0]           bit_sel_reg,   bit_sel_next;
    logic                 set_val_reg,   set_val_next;
    logic                 in_range_reg,  in_range_next;
    logic                 bit_val_reg,   bit_val_next;
    logic                 rsp_found_reg, rsp_found_next;
    logic [BIT_IDX_W-1:0] rsp_start_reg, rsp_start_next;
    logic                 rsp_bit_reg,   rsp_bit_next;

    logic [CW-1:0]        used_bytes;
    logic [UW-1:0]        map_ext;
    logic                 accept;
    logic                 issue;
    logic                 out_free;
    logic [BYTE_IDX_W-1:0] req_byte;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [BYTE_W-1:0]    ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [BYTE_W-1:0]    ram_rdata;
    logic [BYTE_W-1:0]    bit_mask;

    run_ctrl_t            run_ctrl;
    run_stat_t            run_stat;

    // Bytes in use, limited to the store
    assign map_ext    = UW'(map_bytes_reg);
    assign used_bytes = (map_ext > UW'(MAP_BYTES)) ? CW'(MAP_BYTES) : CW'(map_ext);

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign req_byte  = req.bit_index[BIT_IDX_W-1:3];
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign issue     = (state_reg == ST_SCAN) && (issue_cnt_reg < used_bytes)
                       && !run_stat.found;
    assign bit_mask  = BYTE_W'(1) << bit_sel_reg;

    // Drive the map memory
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '0;
        ram_raddr = addr_reg;
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
        end
        else if (state_reg == ST_BIT_EV && kind_reg == KIND_SET && in_range_reg)
        begin
            ram_we    = 1'b1;
            ram_wdata = set_val_reg ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
        end
        if (state_reg == ST_SCAN)
        begin
            ram_raddr = AW'(issue_cnt_reg);
        end
    end

    // Control the run unit
    assign run_ctrl.init       = accept && (req.kind == KIND_SCAN);
    assign run_ctrl.eval       = pend_reg;
    assign run_ctrl.run_length = req.run_length;

    // Sequence one item
    always_comb
    begin
        state_next     = state_reg;
        map_bytes_next = cfg_we ? cfg_wdata : map_bytes_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_item_next  = clr_item_reg;
        issue_cnt_next = issue_cnt_reg;
        pend_next      = issue;
        eval_idx_next  = issue ? issue_cnt_reg : eval_idx_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        bit_sel_next   = bit_sel_reg;
        set_val_next   = set_val_reg;
        in_range_next  = in_range_reg;
        bit_val_next   = bit_val_reg;
        rsp_found_next = rsp_found_reg;
        rsp_start_next = rsp_start_reg;
        rsp_bit_next   = rsp_bit_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(MAP_BYTES - 1))
                begin
                    clr_cnt_next  = '0;
                    clr_item_next = 1'b0;
                    state_next    = clr_item_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next      = req.kind;
                    addr_next      = AW'(req_byte);
                    bit_sel_next   = req.bit_index[2:0];
                    set_val_next   = req.set_value;
                    in_range_next  = CMPW'(req_byte) < CMPW'(used_bytes);
                    bit_val_next   = 1'b0;
                    issue_cnt_next = '0;
                    case (req.kind)
                        KIND_SCAN:
                        begin
                            state_next = ST_SCAN;
                        end
                        KIND_CLEAR:
                        begin
                            clr_item_next = 1'b1;
                            clr_cnt_next  = '0;
                            state_next    = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_BIT_RD;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    issue_cnt_next = issue_cnt_reg + CW'(1);
                end
                if (run_stat.found || (!issue && !pend_reg))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_BIT_RD:
            begin
                state_next = ST_BIT_EV;
            end
            ST_BIT_EV:
            begin
                bit_val_next = (kind_reg == KIND_TEST) && in_range_reg
                               && ram_rdata[bit_sel_reg];
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_found_next = (kind_reg == KIND_SCAN) && run_stat.found;
                    rsp_start_next = (kind_reg == KIND_SCAN) ? run_stat.start_index : '0;
                    rsp_bit_next   = bit_val_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            map_bytes_reg <= MAP_CFG_RESET;
            clr_cnt_reg   <= '0;
            clr_item_reg  <= 1'b0;
            issue_cnt_reg <= '0;
            pend_reg      <= 1'b0;
            eval_idx_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            map_bytes_reg <= map_bytes_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_item_reg  <= clr_item_next;
            issue_cnt_reg <= issue_cnt_next;
            pend_reg      <= pend_next;
            eval_idx_reg  <= eval_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold item payload
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        addr_reg      <= addr_next;
        bit_sel_reg   <= bit_sel_next;
        set_val_reg   <= set_val_next;
        in_range_reg  <= in_range_next;
        bit_val_reg   <= bit_val_next;
        rsp_found_reg <= rsp_found_next;
        rsp_start_reg <= rsp_start_next;
        rsp_bit_reg   <= rsp_bit_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.found       = rsp_found_reg;
    assign rsp.start_index = rsp_start_reg;
    assign rsp.bit_value   = rsp_bit_reg;

    bra_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAP_BYTES)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bra_run_unit #(
        .CW (CW)
    ) u_run_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (run_ctrl),
        .byte_num  (eval_idx_reg),
        .byte_data (ram_rdata),
        .stat      (run_stat)
    );

    // An accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("request taken while busy");

    // A byte under evaluation lies inside the map in use
    a_eval_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (eval_idx_reg < used_bytes))
        else $error("scan evaluated a byte beyond the map");

    // A new result only comes out of the finish step
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the finish step");

    // The finish step hands over once the output register is free
    a_done_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (rsp_valid_reg && state_reg == ST_IDLE))
        else $error("finished item not handed over");

endmodule

`default_nettype wire

// ===== hdl/bra_ram.sv =====
// ----------------------------------------------------------------------------
// bra_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 512
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/bra_run_unit.sv =====
// ----------------------------------------------------------------------------
// bra_run_unit
// Run counter: folds one map byte per step into the free-run count
// and records the start of the first run that reaches the wanted length.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_run_unit #(
    parameter int unsigned CW = 10
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire bra_pkg::run_ctrl_t        ctrl,
    input  wire logic [CW-1:0]             byte_num,
    input  wire logic [bra_pkg::BYTE_W-1:0] byte_data,
    output bra_pkg::run_stat_t             stat
);
    import bra_pkg::*;

    logic [RUN_LEN_W-1:0] run_reg,   run_next;
    logic [RUN_LEN_W-1:0] len_reg,   len_next;
    logic                 found_reg, found_next;
    logic [BIT_IDX_W-1:0] start_reg, start_next;

    // Walk the eight bits of one byte, lowest unit first
    always_comb
    begin
        logic [RUN_LEN_W-1:0] run_v;
        logic                 hit;
        logic [BIT_IDX_W-1:0] st;
        logic [CW+2:0]        pos;

        run_v      = run_reg;
        hit        = found_reg;
        st         = start_reg;
        pos        = '0;
        run_next   = run_reg;
        len_next   = len_reg;
        found_next = found_reg;
        start_next = start_reg;

        if (ctrl.init)
        begin
            run_next   = '0;
            len_next   = (ctrl.run_length == '0) ? RUN_LEN_W'(1) : ctrl.run_length;
            found_next = 1'b0;
            start_next = '0;
        end
        else if (ctrl.eval && !found_reg)
        begin
            for (int k = 0; k < BYTE_W; k++)
            begin
                if (!hit)
                begin
                    if (byte_data[k])
                    begin
                        run_v = '0;
                    end
                    else
                    begin
                        run_v = run_v + RUN_LEN_W'(1);
                    end
                    if (run_v == len_reg)
                    begin
                        hit = 1'b1;
                        pos = {byte_num, 3'(k)};
                        st  = BIT_IDX_W'(pos) + BIT_IDX_W'(1) - len_reg[BIT_IDX_W-1:0];
                    end
                end
            end
            run_next   = run_v;
            found_next = hit;
            start_next = st;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= '0;
            len_reg   <= RUN_LEN_W'(1);
            found_reg <= 1'b0;
            start_reg <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            len_reg   <= len_next;
            found_reg <= found_next;
            start_reg <= start_next;
        end
    end

    assign stat.found       = found_reg;
    assign stat.start_index = start_reg;

    // A hit never moves once taken
    a_found_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg && !ctrl.init) |=> (found_reg && $stable(start_reg)))
        else $error("run unit lost a found run");

    // The count never passes the wanted length before a hit
    a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (!found_reg && !ctrl.init && $past(!ctrl.init)) |-> (run_reg < len_reg))
        else $error("run count passed length without a hit");

    // A hit always carries a full run
    a_hit_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(found_reg) |-> (run_reg == len_reg))
        else $error("hit without a full run");

endmodule

`default_nettype wire

// ===== tb/sv/bra_alloc_checker.sv =====
// ----------------------------------------------------------------------------
// bra_alloc_checker
// Watches the request, response and map length ports of the allocator, keeps
// its own copy of the allocation map and compares every response item, field
// by field, with the result predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_alloc_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bra_pkg::MAP_CFG_W-1:0] cfg_wdata,
    bra_req_if                                 req,
    bra_rsp_if                                 rsp,
    output int unsigned                        fail_count,
    output int unsigned                        n_outstanding,
    output int unsigned                        n_results,
    output int unsigned                        n_runs_found
);
    timeunit 1ns;
    timeprecision 1ps;

    import bra_pkg::*;

    typedef struct packed {
        logic                 found;
        logic [BIT_IDX_W-1:0] start_index;
        logic                 bit_value;
    } alloc_result_t;

    // Shadow allocation map and map length register
    logic [BYTE_W-1:0]    alloc_map [MAP_BYTES_DEF];
    logic [MAP_CFG_W-1:0] map_len;

    // Predicted results, oldest first
    alloc_result_t        pending_results [$];

    // Bytes of the store that are in use; lengths above the store are clipped
    function automatic int unsigned bytes_in_use();
        if (int'(map_len) > MAP_BYTES_DEF)
            return MAP_BYTES_DEF;
        return int'(map_len);
    endfunction

    // Read one unit; units beyond the map in use read as free
    function automatic logic unit_taken(int unsigned idx);
        int unsigned byte_sel;
        byte_sel = idx >> 3;
        if (byte_sel >= bytes_in_use())
            return 1'b0;
        return alloc_map[byte_sel][idx % 8];
    endfunction

    // Work out the result of one request and update the shadow map
    function automatic alloc_result_t apply_request(logic [KIND_W-1:0]    kind,
                                                    logic [BIT_IDX_W-1:0] bit_index,
                                                    logic                 set_value,
                                                    logic [RUN_LEN_W-1:0] run_length);
        alloc_result_t res;
        int unsigned   want;
        int unsigned   run;
        int unsigned   total;
        int unsigned   byte_sel;
        logic          hit;
        res = '0;
        case (kind)
            KIND_SCAN: begin
                // Zero length counts as one; the run must end inside the map
                want  = (run_length == '0) ? 1 : int'(run_length);
                total = bytes_in_use() * 8;
                run   = 0;
                hit   = 1'b0;
                for (int unsigned i = 0; i < total && !hit; i++) begin
                    if (unit_taken(i))
                        run = 0;
                    else
                        run++;
                    if (run == want) begin
                        hit             = 1'b1;
                        res.found       = 1'b1;
                        res.start_index = BIT_IDX_W'(i + 1 - want);
                    end
                end
            end
            KIND_TEST: begin
                res.bit_value = unit_taken(int'(bit_index));
            end
            KIND_SET: begin
                // Drop writes beyond the map in use
                byte_sel = int'(bit_index) >> 3;
                if (byte_sel < bytes_in_use())
                    alloc_map[byte_sel][bit_index[2:0]] = set_value;
            end
            KIND_CLEAR: begin
                // Clear reaches the whole store, also past the map in use
                for (int i = 0; i < MAP_BYTES_DEF; i++)
                    alloc_map[i] = '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Print one line for a mismatch and count it
    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        fail_count++;
        $display("MISMATCH %s: got %0d, expected %0d (response item %0d)",
                 what, got, want, n_results);
    endtask

    // Compare responses first, then record new requests and map length writes
    always @(posedge clk or negedge rst_n) begin
        alloc_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < MAP_BYTES_DEF; i++)
                alloc_map[i] = '0;
            map_len = MAP_CFG_RESET;
            pending_results.delete();
            fail_count    = 0;
            n_outstanding <= 0;
            n_results     <= 0;
            n_runs_found  <= 0;
        end
        else begin
            if (rsp.valid && rsp.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("response item with no request outstanding", 1, 0);
                end
                else begin
                    want = pending_results.pop_front();
                    if (rsp.found !== want.found)
                        report_mismatch("found", int'(rsp.found), int'(want.found));
                    if (rsp.start_index !== want.start_index)
                        report_mismatch("start_index", int'(rsp.start_index),
                                        int'(want.start_index));
                    if (rsp.bit_value !== want.bit_value)
                        report_mismatch("bit_value", int'(rsp.bit_value),
                                        int'(want.bit_value));
                    if (want.found)
                        n_runs_found <= n_runs_found + 1;
                end
                n_results <= n_results + 1;
            end
            if (req.valid && req.ready)
                pending_results.push_back(apply_request(req.kind, req.bit_index,
                                                        req.set_value, req.run_length));
            if (cfg_we)
                map_len = cfg_wdata;
            n_outstanding <= pending_results.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the bitmap run allocator: directed corner cases,
// then phases of random requests under several map lengths, with random gaps
// on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bra_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [MAP_CFG_W-1:0] cfg_wdata;

    bra_req_if req_ch ();
    bra_rsp_if rsp_ch ();

    int unsigned fail_count;
    int unsigned n_outstanding;
    int unsigned n_results;
    int unsigned n_runs_found;

    // Stimulus bookkeeping
    bit          sender_no_gap;
    bit          receiver_no_stall;
    int unsigned n_requests;
    int unsigned n_settings;
    int unsigned unit_span;

    bitmap_run_allocator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    bra_alloc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .n_outstanding (n_outstanding),
        .n_results     (n_results),
        .n_runs_found  (n_runs_found)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hard stop for a hung run
    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Send one request item after a random gap and wait until it is taken
    task automatic issue_request(logic [KIND_W-1:0] kind, int unsigned bit_index,
                                 int unsigned set_value, int unsigned run_length);
        int unsigned gap;
        gap = sender_no_gap ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.kind       <= kind;
        req_ch.bit_index  <= BIT_IDX_W'(bit_index);
        req_ch.set_value  <= 1'(set_value);
        req_ch.run_length <= RUN_LEN_W'(run_length);
        req_ch.valid      <= 1'b1;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
        n_requests++;
    endtask

    // Hold off requests until every outstanding result has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (n_outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the map length while the block is idle
    task automatic set_map_length(int unsigned len);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= MAP_CFG_W'(len);
        @(posedge clk);
        cfg_we    <= 1'b0;
        n_settings++;
        unit_span = ((len > MAP_BYTES_DEF) ? MAP_BYTES_DEF : len) * 8;
    endtask

    // Mostly units inside the map in use, sometimes anywhere
    function automatic int unsigned pick_unit();
        if (unit_span == 0 || $urandom_range(0, 4) == 0)
            return $urandom_range(0, 4095);
        return $urandom_range(0, unit_span - 1);
    endfunction

    // Mostly short runs, with some long, oversized and zero lengths
    function automatic int unsigned pick_run_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(1, 8);
        if (r < 80)
            return $urandom_range(1, (unit_span == 0) ? 1 : unit_span);
        if (r < 90)
            return $urandom_range(0, 8191);
        if (r < 95)
            return 0;
        return unit_span + $urandom_range(0, 1);
    endfunction

    // Random mix: runs of sets build fragments, scans and tests probe them
    task automatic run_random_phase(int unsigned n_items);
        int unsigned count;
        int unsigned r;
        int unsigned start;
        int unsigned cnt;
        int unsigned val;
        count = 0;
        while (count < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                start = pick_unit();
                cnt   = $urandom_range(1, 12);
                val   = ($urandom_range(0, 3) != 0) ? 1 : 0;
                for (int unsigned k = 0; k < cnt; k++)
                    issue_request(KIND_SET, (start + k) % 4096, val, $urandom_range(0, 8191));
                count += cnt;
            end
            else if (r < 62) begin
                issue_request(KIND_SCAN, $urandom_range(0, 4095), $urandom_range(0, 1),
                              pick_run_length());
                count++;
            end
            else if (r < 80) begin
                issue_request(KIND_TEST, pick_unit(), $urandom_range(0, 1),
                              $urandom_range(0, 8191));
                count++;
            end
            else if (r < 88) begin
                issue_request(KIND_SET, $urandom_range(0, 4095), $urandom_range(0, 1),
                              $urandom_range(0, 8191));
                count++;
            end
            else if (r < 91) begin
                issue_request(KIND_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 1),
                              $urandom_range(0, 8191));
                count++;
            end
            else if (r < 93) begin
                wait_drained();
            end
            else begin
                // Walk a few neighboring units
                start = pick_unit();
                cnt   = $urandom_range(1, 6);
                for (int unsigned k = 0; k < cnt; k++)
                    issue_request(KIND_TEST, (start + k) % 4096, $urandom_range(0, 1),
                                  $urandom_range(0, 8191));
                count += cnt;
            end
        end
    endtask

    // Response side: random stalls, with stretches of none
    initial
    begin
        int unsigned stall;
        rsp_ch.ready      <= 1'b0;
        receiver_no_stall = 1'b0;
        forever begin
            if ($urandom_range(0, 39) == 0)
                receiver_no_stall = ($urandom_range(0, 2) == 0);
            stall = receiver_no_stall ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
        end
    end

    // Main sequence
    initial
    begin
        int unsigned forced_len [4];
        int unsigned len;
        forced_len = '{1, 1023, 0, 512};
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= MAP_CFG_RESET;
        req_ch.valid      <= 1'b0;
        req_ch.kind       <= KIND_SCAN;
        req_ch.bit_index  <= '0;
        req_ch.set_value  <= 1'b0;
        req_ch.run_length <= '0;
        sender_no_gap = 1'b0;
        n_requests    = 0;
        n_settings    = 0;
        unit_span     = MAP_BYTES_DEF * 8;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait out the clearing sweep after reset
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);

        // Full map after reset: first and last units, zero, exact and oversized runs
        issue_request(KIND_SCAN, 0, 0, 1);
        issue_request(KIND_TEST, 0, 0, 0);
        issue_request(KIND_SET, 0, 1, 0);
        issue_request(KIND_TEST, 0, 0, 0);
        issue_request(KIND_SCAN, 0, 0, 1);
        issue_request(KIND_SET, 4095, 1, 0);
        issue_request(KIND_TEST, 4095, 0, 0);
        issue_request(KIND_SCAN, 0, 0, 4094);
        issue_request(KIND_SCAN, 0, 0, 4095);
        issue_request(KIND_SCAN, 0, 0, 0);
        issue_request(KIND_SCAN, 0, 0, 8191);
        issue_request(KIND_SET, 0, 0, 0);
        issue_request(KIND_SCAN, 0, 0, 4095);
        issue_request(KIND_CLEAR, 0, 0, 0);
        issue_request(KIND_SCAN, 0, 0, 4096);

        // One byte in use: run stops at the map end, out of range set and test
        set_map_length(1);
        issue_request(KIND_SET, 3, 1, 0);
        issue_request(KIND_SCAN, 0, 0, 4);
        issue_request(KIND_SCAN, 0, 0, 5);
        issue_request(KIND_SET, 8, 1, 0);
        issue_request(KIND_TEST, 8, 0, 0);
        issue_request(KIND_TEST, 3, 0, 0);

        // Length beyond the store acts as the full store
        set_map_length(1023);
        issue_request(KIND_TEST, 8, 0, 0);
        issue_request(KIND_SET, 4095, 1, 0);
        issue_request(KIND_TEST, 4095, 0, 0);

        // Empty map; clear still reaches the whole store
        set_map_length(0);
        issue_request(KIND_SCAN, 0, 0, 1);
        issue_request(KIND_TEST, 3, 0, 0);
        issue_request(KIND_SET, 0, 1, 0);
        issue_request(KIND_CLEAR, 0, 0, 0);
        set_map_length(512);
        issue_request(KIND_TEST, 4095, 0, 0);
        issue_request(KIND_TEST, 3, 0, 0);

        // Random phases: extremes first, then mostly small maps
        for (int p = 0; p < 12; p++) begin
            if (p < 4) begin
                len = forced_len[p];
            end
            else begin
                case ($urandom_range(0, 5))
                    0:       len = $urandom_range(1, 4);
                    1:       len = $urandom_range(5, 32);
                    2:       len = $urandom_range(33, 128);
                    3:       len = $urandom_range(129, 512);
                    4:       len = $urandom_range(513, 1023);
                    default: len = $urandom_range(1, 16);
                endcase
            end
            set_map_length(len);
            sender_no_gap = ($urandom_range(0, 3) == 0);
            run_random_phase((len == 0) ? 20 : 52);
        end

        // Drain and let any stray response show up
        sender_no_gap = 1'b0;
        wait_drained();
        repeat (16) @(posedge clk);

        $display("Sent %0d requests of all four kinds over %0d map length settings (0 to 1023)",
                 n_requests, n_settings);
        $display("Checked %0d response items, %0d scans found a free run, %0d mismatches",
                 n_results, n_runs_found, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
